// ===== hdl/ctd_pkg.sv =====
// Shared types and widths for the CAN telemetry decoder and plausibility monitor.
package ctd_pkg;

   localparam int unsigned NUM_CHANNELS = 24;
   localparam int unsigned CHANNEL_W    = 5;
   localparam int unsigned READING_W    = 16;
   localparam int unsigned FRAME_ID_W   = 11;

   // Classified queue word: which frame slot it updates, or a refresh tick.
   typedef enum logic [2:0] {
      KIND_ENGINE_FRAME,
      KIND_BRAKE_FRAME,
      KIND_TEMP_FRAME,
      KIND_STATUS_FRAME,
      KIND_LAP_FRAME,
      KIND_TICK
   } kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [7:0][7:0] bytes;      // bytes[i] is payload byte i
      logic [12:0]     scaled;     // big-endian pressure word divided by ten
      logic [9:0]      last_lap_q;
      logic [6:0]      last_lap_r;
      logic [9:0]      cur_lap_q;
      logic [6:0]      cur_lap_r;
   } entry_type;

   typedef struct packed {
      logic [10:0] frame_id_base;
      logic [7:0]  throttle_limit;
      logic [12:0] brake_limit;
      logic [5:0]  fault_ticks;
      logic [15:0] rpm_limit;
      logic [15:0] fuel_pressure_limit;
   } cfg_type;

endpackage

// ===== hdl/ctd_front.sv =====
// Front end: accepts words, drops foreign frames, prescales fields for the queue.
module ctd_front
   import ctd_pkg::*;
(
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [FRAME_ID_W-1:0] req_frame_id,
   input  logic [7:0]            req_byte_0,
   input  logic [7:0]            req_byte_1,
   input  logic [7:0]            req_byte_2,
   input  logic [7:0]            req_byte_3,
   input  logic [7:0]            req_byte_4,
   input  logic [7:0]            req_byte_5,
   input  logic [7:0]            req_byte_6,
   input  logic [7:0]            req_byte_7,
   input  logic                  queue_full,
   output logic                  push,
   output entry_type             push_entry
);

   logic [FRAME_ID_W-1:0] offs;
   logic                  keep;
   logic [15:0]           div_src;
   logic [31:0]           div10_prod;
   logic [16:0]           last_split;
   logic [16:0]           cur_split;

   // Exact x/100 for 16-bit x: (x/4)/25 by reciprocal, remainder by back-multiply.
   function automatic logic [16:0] split_100(logic [15:0] x);
      logic [26:0] prod;
      logic [9:0]  q;
      logic [15:0] qx100;
      logic [15:0] rem;
      prod  = {13'd0, x[15:2]} * 27'd5243;
      q     = prod[26:17];
      qx100 = {6'd0, q} * 16'd100;
      rem   = x - qx100;
      return {q, rem[6:0]};
   endfunction

   always_comb begin
      offs = req_frame_id - cfg.frame_id_base;
      keep = req_mode || (offs < 11'd5);
   end

   // hold the sender off while the queue is full or being reset
   assign req_stall = queue_full || reset;
   assign push      = req_valid && !req_stall && keep;

   always_comb begin
      div_src    = (offs == 11'd1) ? {req_byte_0, req_byte_1} : {req_byte_2, req_byte_3};
      div10_prod = {16'd0, div_src} * 32'd52429;
      last_split = split_100({req_byte_0, req_byte_1});
      cur_split  = split_100({req_byte_2, req_byte_3});
   end

   always_comb begin
      if (req_mode) begin
         push_entry.kind = KIND_TICK;
      end else begin
         case (offs)
            11'd0:   push_entry.kind = KIND_ENGINE_FRAME;
            11'd1:   push_entry.kind = KIND_BRAKE_FRAME;
            11'd2:   push_entry.kind = KIND_TEMP_FRAME;
            11'd3:   push_entry.kind = KIND_STATUS_FRAME;
            default: push_entry.kind = KIND_LAP_FRAME;
         endcase
      end
      push_entry.bytes = {req_byte_7, req_byte_6, req_byte_5, req_byte_4,
                          req_byte_3, req_byte_2, req_byte_1, req_byte_0};
      push_entry.scaled     = div10_prod[31:19];
      push_entry.last_lap_q = last_split[16:7];
      push_entry.last_lap_r = last_split[6:0];
      push_entry.cur_lap_q  = cur_split[16:7];
      push_entry.cur_lap_r  = cur_split[6:0];
   end

endmodule

// ===== hdl/ctd_queue.sv =====
// Short FIFO of classified words between front end and back end.
module ctd_queue
   import ctd_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/ctd_back.sv =====
// Back end: telemetry registers, plausibility check and 24-channel result burst.
module ctd_back
   import ctd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  entry_type            pop_entry,
   input  logic                 queue_empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [READING_W-1:0] rsp_reading,
   output logic                 rsp_last_channel
);

   typedef enum logic {
      ST_DISPATCH,
      ST_EMIT
   } state_type;

   localparam logic [1:0] FAULT_OK          = 2'd0;
   localparam logic [1:0] FAULT_IMPLAUSIBLE = 2'd1;
   localparam logic [1:0] FAULT_LATCHED     = 2'd2;

   localparam logic [CHANNEL_W-1:0] CH_RPM        = 5'd0;
   localparam logic [CHANNEL_W-1:0] CH_OIL_PRESS  = 5'd1;
   localparam logic [CHANNEL_W-1:0] CH_FUEL_PRESS = 5'd2;
   localparam logic [CHANNEL_W-1:0] CH_THROTTLE   = 5'd3;
   localparam logic [CHANNEL_W-1:0] CH_SPEED      = 5'd4;
   localparam logic [CHANNEL_W-1:0] CH_BRAKE      = 5'd5;
   localparam logic [CHANNEL_W-1:0] CH_GEAR       = 5'd6;
   localparam logic [CHANNEL_W-1:0] CH_BIAS       = 5'd7;
   localparam logic [CHANNEL_W-1:0] CH_ENG_TEMP   = 5'd8;
   localparam logic [CHANNEL_W-1:0] CH_OIL_TEMP   = 5'd9;
   localparam logic [CHANNEL_W-1:0] CH_BATTERY    = 5'd10;
   localparam logic [CHANNEL_W-1:0] CH_RADIO      = 5'd11;
   localparam logic [CHANNEL_W-1:0] CH_DRS        = 5'd12;
   localparam logic [CHANNEL_W-1:0] CH_THR_STATE  = 5'd13;
   localparam logic [CHANNEL_W-1:0] CH_LAUNCH     = 5'd14;
   localparam logic [CHANNEL_W-1:0] CH_AUTOSHIFT  = 5'd15;
   localparam logic [CHANNEL_W-1:0] CH_CLUTCH     = 5'd16;
   localparam logic [CHANNEL_W-1:0] CH_CUR_LAP_Q  = 5'd17;
   localparam logic [CHANNEL_W-1:0] CH_CUR_LAP_R  = 5'd18;
   localparam logic [CHANNEL_W-1:0] CH_LAST_LAP_Q = 5'd19;
   localparam logic [CHANNEL_W-1:0] CH_LAST_LAP_R = 5'd20;
   localparam logic [CHANNEL_W-1:0] CH_LAP_COUNT  = 5'd21;
   localparam logic [CHANNEL_W-1:0] CH_FAULT      = 5'd22;
   localparam logic [CHANNEL_W-1:0] CH_FUEL       = 5'd23;
   localparam logic [CHANNEL_W-1:0] CH_FINAL      = CHANNEL_W'(NUM_CHANNELS - 1);

   state_type            state_ff;
   logic [CHANNEL_W-1:0] chan_ff;
   logic                 rsp_valid_ff;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   logic [READING_W-1:0] rsp_reading_ff;
   logic                 rsp_last_ff;

   logic [15:0] engine_rpm_ff;
   logic [12:0] oil_pressure_ff;
   logic [15:0] fuel_pressure_ff;
   logic [7:0]  throttle_ff;
   logic [7:0]  vehicle_speed_ff;
   logic [12:0] brake_pressure_ff;
   logic [7:0]  gear_position_ff;
   logic [7:0]  brake_bias_ff;
   logic [7:0]  engine_temp_ff;
   logic [7:0]  oil_temp_ff;
   logic [7:0]  battery_volts_ff;
   logic [7:0]  status_bits_ff;
   logic [9:0]  last_lap_q_ff;
   logic [6:0]  last_lap_r_ff;
   logic [9:0]  cur_lap_q_ff;
   logic [6:0]  cur_lap_r_ff;
   logic [15:0] lap_count_ff;
   logic [5:0]  implausible_count_ff;
   logic        fault_latched_ff;
   logic [1:0]  fault_code_ff;
   logic        fuel_ok_ff;

   logic        out_free;
   logic        hit;
   logic [5:0]  count_in;
   logic        latched_in;
   logic [1:0]  fault_code_in;
   logic        fuel_ok_in;
   logic [READING_W-1:0] reading_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_DISPATCH) && !queue_empty;

   // Plausibility check on the current registers, applied when a tick pops.
   always_comb begin
      hit           = (throttle_ff > cfg.throttle_limit) && (brake_pressure_ff > cfg.brake_limit);
      count_in      = implausible_count_ff;
      latched_in    = fault_latched_ff;
      fault_code_in = FAULT_LATCHED;
      if (!fault_latched_ff) begin
         if (hit) begin
            if (implausible_count_ff < cfg.fault_ticks) begin
               count_in = implausible_count_ff + 6'd1;
            end
         end else begin
            count_in = '0;
         end
         latched_in = (count_in >= cfg.fault_ticks);
         if (latched_in) begin
            fault_code_in = FAULT_LATCHED;
         end else if (hit) begin
            fault_code_in = FAULT_IMPLAUSIBLE;
         end else begin
            fault_code_in = FAULT_OK;
         end
      end
      fuel_ok_in = !((engine_rpm_ff > cfg.rpm_limit) &&
                     (fuel_pressure_ff < cfg.fuel_pressure_limit));
   end

   always_comb begin
      case (chan_ff)
         CH_RPM:        reading_in = engine_rpm_ff;
         CH_OIL_PRESS:  reading_in = {3'd0, oil_pressure_ff};
         CH_FUEL_PRESS: reading_in = fuel_pressure_ff;
         CH_THROTTLE:   reading_in = {8'd0, throttle_ff};
         CH_SPEED:      reading_in = {8'd0, vehicle_speed_ff};
         CH_BRAKE:      reading_in = {3'd0, brake_pressure_ff};
         CH_GEAR:       reading_in = {8'd0, gear_position_ff};
         CH_BIAS:       reading_in = {8'd0, brake_bias_ff};
         CH_ENG_TEMP:   reading_in = {8'd0, engine_temp_ff};
         CH_OIL_TEMP:   reading_in = {8'd0, oil_temp_ff};
         CH_BATTERY:    reading_in = {8'd0, battery_volts_ff};
         CH_RADIO:      reading_in = {15'd0, status_bits_ff[7]};
         CH_DRS:        reading_in = {15'd0, status_bits_ff[6]};
         CH_THR_STATE:  reading_in = {13'd0, status_bits_ff[5:3]};
         CH_LAUNCH:     reading_in = {15'd0, status_bits_ff[2]};
         CH_AUTOSHIFT:  reading_in = {15'd0, status_bits_ff[1]};
         CH_CLUTCH:     reading_in = {15'd0, status_bits_ff[0]};
         CH_CUR_LAP_Q:  reading_in = {6'd0, cur_lap_q_ff};
         CH_CUR_LAP_R:  reading_in = {9'd0, cur_lap_r_ff};
         CH_LAST_LAP_Q: reading_in = {6'd0, last_lap_q_ff};
         CH_LAST_LAP_R: reading_in = {9'd0, last_lap_r_ff};
         CH_LAP_COUNT:  reading_in = lap_count_ff;
         CH_FAULT:      reading_in = {14'd0, fault_code_ff};
         CH_FUEL:       reading_in = {15'd0, fuel_ok_ff};
         default:       reading_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_DISPATCH;
         chan_ff              <= '0;
         rsp_valid_ff         <= 1'b0;
         rsp_channel_ff       <= '0;
         rsp_reading_ff       <= '0;
         rsp_last_ff          <= 1'b0;
         engine_rpm_ff        <= '0;
         oil_pressure_ff      <= '0;
         fuel_pressure_ff     <= '0;
         throttle_ff          <= '0;
         vehicle_speed_ff     <= '0;
         brake_pressure_ff    <= '0;
         gear_position_ff     <= '0;
         brake_bias_ff        <= '0;
         engine_temp_ff       <= '0;
         oil_temp_ff          <= '0;
         battery_volts_ff     <= '0;
         status_bits_ff       <= '0;
         last_lap_q_ff        <= '0;
         last_lap_r_ff        <= '0;
         cur_lap_q_ff         <= '0;
         cur_lap_r_ff         <= '0;
         lap_count_ff         <= 16'd1;
         implausible_count_ff <= '0;
         fault_latched_ff     <= 1'b0;
         fault_code_ff        <= FAULT_OK;
         fuel_ok_ff           <= 1'b1;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= (state_ff == ST_EMIT);
            if (state_ff == ST_EMIT) begin
               rsp_channel_ff <= chan_ff;
               rsp_reading_ff <= reading_in;
               rsp_last_ff    <= (chan_ff == CH_FINAL);
            end
         end
         case (state_ff)
            ST_DISPATCH: begin
               if (pop) begin
                  case (pop_entry.kind)
                     KIND_ENGINE_FRAME: begin
                        engine_rpm_ff    <= {pop_entry.bytes[0], pop_entry.bytes[1]};
                        oil_pressure_ff  <= pop_entry.scaled;
                        fuel_pressure_ff <= {pop_entry.bytes[4], pop_entry.bytes[5]};
                        throttle_ff      <= pop_entry.bytes[6];
                        vehicle_speed_ff <= pop_entry.bytes[7];
                     end
                     KIND_BRAKE_FRAME: begin
                        brake_pressure_ff <= pop_entry.scaled;
                        gear_position_ff  <= pop_entry.bytes[6];
                        brake_bias_ff     <= pop_entry.bytes[7];
                     end
                     KIND_TEMP_FRAME: begin
                        engine_temp_ff   <= pop_entry.bytes[0];
                        oil_temp_ff      <= pop_entry.bytes[1];
                        battery_volts_ff <= pop_entry.bytes[2];
                     end
                     KIND_STATUS_FRAME: begin
                        status_bits_ff <= {pop_entry.bytes[0][7:3], pop_entry.bytes[1][7:5]};
                     end
                     KIND_LAP_FRAME: begin
                        last_lap_q_ff <= pop_entry.last_lap_q;
                        last_lap_r_ff <= pop_entry.last_lap_r;
                        cur_lap_q_ff  <= pop_entry.cur_lap_q;
                        cur_lap_r_ff  <= pop_entry.cur_lap_r;
                        lap_count_ff  <= {pop_entry.bytes[4], pop_entry.bytes[5]};
                     end
                     KIND_TICK: begin
                        implausible_count_ff <= count_in;
                        fault_latched_ff     <= latched_in;
                        fault_code_ff        <= fault_code_in;
                        fuel_ok_ff           <= fuel_ok_in;
                        chan_ff              <= '0;
                        state_ff             <= ST_EMIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_EMIT: begin
               // advance one channel per word taken by the output register
               if (out_free) begin
                  if (chan_ff == CH_FINAL) begin
                     state_ff <= ST_DISPATCH;
                  end else begin
                     chan_ff <= chan_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_DISPATCH;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_reading      = rsp_reading_ff;
   assign rsp_last_channel = rsp_last_ff;

endmodule

// ===== hdl/can_telemetry_decode_bspd_monitor.sv =====
// Top level of the CAN telemetry decoder with brake/throttle plausibility monitor.
//
// Input channel (req_*): one word is a received CAN frame (req_mode 0) or a
// refresh tick (req_mode 1), taken when req_valid is high and req_stall low.
// Frames with identifiers frame_id_base+0..+4 update the telemetry registers
// and give no result; other identifiers are dropped at the front end.
// A tick runs the plausibility and fuel pressure checks and gives a burst of
// 24 result words on rsp_*, channels 0..23, rsp_last_channel on the last.
// Words pass through a QUEUE_DEPTH-entry queue; the back end retires a frame
// as soon as it takes it from the queue, and a tick by taking it and then
// giving its 24 results at one per cycle, paced by the output register and
// held while rsp_stall holds a word there; it takes no new word meanwhile.
// req_stall rises only when the queue fills and while reset is high.
// While rsp_stall is high the output word holds; input keeps flowing until
// the queue fills. Configuration writes (csr_*) are always taken.
// Reset restores register defaults, zeroes telemetry (lap count one), clears
// the fault counter and latch, and empties the queue.
module can_telemetry_decode_bspd_monitor
   import ctd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [FRAME_ID_W-1:0] req_frame_id,
   input  logic [7:0]            req_byte_0,
   input  logic [7:0]            req_byte_1,
   input  logic [7:0]            req_byte_2,
   input  logic [7:0]            req_byte_3,
   input  logic [7:0]            req_byte_4,
   input  logic [7:0]            req_byte_5,
   input  logic [7:0]            req_byte_6,
   input  logic [7:0]            req_byte_7,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHANNEL_W-1:0]  rsp_channel,
   output logic [READING_W-1:0]  rsp_reading,
   output logic                  rsp_last_channel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam logic [2:0] CSR_FRAME_ID_BASE  = 3'd0;
   localparam logic [2:0] CSR_THROTTLE_LIMIT = 3'd1;
   localparam logic [2:0] CSR_BRAKE_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_FAULT_TICKS    = 3'd3;
   localparam logic [2:0] CSR_RPM_LIMIT      = 3'd4;
   localparam logic [2:0] CSR_FUEL_LIMIT     = 3'd5;

   cfg_type   cfg_ff;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type pop_entry;
   logic      queue_full;
   logic      queue_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_id_base       <= 11'd1600;
         cfg_ff.throttle_limit      <= 8'd21;
         cfg_ff.brake_limit         <= 13'd1;
         cfg_ff.fault_ticks         <= 6'd33;
         cfg_ff.rpm_limit           <= 16'd1000;
         cfg_ff.fuel_pressure_limit <= 16'd320;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_ID_BASE:  cfg_ff.frame_id_base       <= csr_data[10:0];
            CSR_THROTTLE_LIMIT: cfg_ff.throttle_limit      <= csr_data[7:0];
            CSR_BRAKE_LIMIT:    cfg_ff.brake_limit         <= csr_data[12:0];
            CSR_FAULT_TICKS:    cfg_ff.fault_ticks         <= csr_data[5:0];
            CSR_RPM_LIMIT:      cfg_ff.rpm_limit           <= csr_data;
            CSR_FUEL_LIMIT:     cfg_ff.fuel_pressure_limit <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ctd_front u_front (
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_frame_id (req_frame_id),
      .req_byte_0   (req_byte_0),
      .req_byte_1   (req_byte_1),
      .req_byte_2   (req_byte_2),
      .req_byte_3   (req_byte_3),
      .req_byte_4   (req_byte_4),
      .req_byte_5   (req_byte_5),
      .req_byte_6   (req_byte_6),
      .req_byte_7   (req_byte_7),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   ctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   ctd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_entry        (pop_entry),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_reading      (rsp_reading),
      .rsp_last_channel (rsp_last_channel)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the CAN telemetry decoder and brake/throttle plausibility monitor.
module tb;
   import ctd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 32;

   typedef enum logic {MODE_FRAME, MODE_TICK} mode_type;
   typedef enum logic [1:0] {FAULT_OK, FAULT_IMPLAUSIBLE, FAULT_LATCHED} fault_type;
   typedef enum logic [2:0] {
      REG_FRAME_ID_BASE, REG_THROTTLE_LIMIT, REG_BRAKE_LIMIT, REG_FAULT_TICKS,
      REG_RPM_LIMIT, REG_FUEL_PRESSURE_LIMIT, REG_SPARE_6, REG_SPARE_7
   } csr_reg_type;
   typedef enum int {
      CH_RPM, CH_OIL_PRESS, CH_FUEL_PRESS, CH_THROTTLE, CH_SPEED, CH_BRAKE, CH_GEAR,
      CH_BIAS, CH_ENGINE_TEMP, CH_OIL_TEMP, CH_BATTERY, CH_RADIO, CH_DRS,
      CH_THROTTLE_STATE, CH_LAUNCH, CH_AUTOSHIFT, CH_CLUTCH, CH_CUR_LAP_HI,
      CH_CUR_LAP_LO, CH_LAST_LAP_HI, CH_LAST_LAP_LO, CH_LAP_COUNT, CH_FAULT, CH_FUEL_OK
   } channel_type;

   typedef struct packed {
      logic                  mode;
      logic [FRAME_ID_W-1:0] id;
      logic [0:7][7:0]       payload;   // payload[i] is byte i
   } can_word_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [READING_W-1:0] reading;
      logic                 last;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = 1'b0;
   logic [FRAME_ID_W-1:0] req_frame_id = '0;
   logic [7:0]            req_byte_0 = '0, req_byte_1 = '0, req_byte_2 = '0, req_byte_3 = '0;
   logic [7:0]            req_byte_4 = '0, req_byte_5 = '0, req_byte_6 = '0, req_byte_7 = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHANNEL_W-1:0]  rsp_channel;
   logic [READING_W-1:0]  rsp_reading;
   logic                  rsp_last_channel;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [2:0]            csr_index = '0;
   logic [15:0]           csr_data = '0;

   // configuration copy
   logic [10:0] id_base    = 11'd1600;
   logic [7:0]  thr_lim    = 8'd21;
   logic [12:0] brk_lim    = 13'd1;
   logic [5:0]  trip_ticks = 6'd33;
   logic [15:0] rpm_lim    = 16'd1000;
   logic [15:0] fuel_lim   = 16'd320;

   // telemetry copy
   logic [15:0] rpm = '0, fuel_p = '0, lap_last = '0, lap_cur = '0, lap_num = 16'd1;
   logic [12:0] oil_p = '0, brake_p = '0;
   logic [7:0]  thr = '0, speed = '0, gear = '0, bias = '0;
   logic [7:0]  eng_t = '0, oil_t = '0, batt = '0, status = '0;
   logic [5:0]  bad_ticks = '0;
   logic        latched = 1'b0;

   can_word_type words_to_send[$];
   reading_type  readings_due[$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   logic         hold_armed = 1'b0;
   logic         hold_done = 1'b0;
   int           hold_left = 0;

   can_telemetry_decode_bspd_monitor u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_frame_id,
      .req_byte_0, .req_byte_1, .req_byte_2, .req_byte_3,
      .req_byte_4, .req_byte_5, .req_byte_6, .req_byte_7,
      .rsp_valid, .rsp_stall, .rsp_channel, .rsp_reading, .rsp_last_channel,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Update telemetry for a frame; for a tick run the checks and queue the 24 readings.
   function automatic void decode_and_report(input can_word_type w);
      logic [10:0]    offs;
      logic [15:0]    wide;
      logic [15:0]    rd [NUM_CHANNELS];
      fault_type      fault;
      reading_type    r;
      if (w.mode == MODE_FRAME) begin
         offs = w.id - id_base;
         if (offs[10:3] == '0 && offs[2:0] <= KIND_LAP_FRAME) begin
            case (kind_type'(offs[2:0]))
               KIND_ENGINE_FRAME: begin
                  rpm = {w.payload[0], w.payload[1]};
                  wide = {w.payload[2], w.payload[3]} / 16'd10;
                  oil_p = wide[12:0];
                  fuel_p = {w.payload[4], w.payload[5]};
                  thr = w.payload[6];
                  speed = w.payload[7];
               end
               KIND_BRAKE_FRAME: begin
                  wide = {w.payload[0], w.payload[1]} / 16'd10;
                  brake_p = wide[12:0];
                  gear = w.payload[6];
                  bias = w.payload[7];
               end
               KIND_TEMP_FRAME: begin
                  eng_t = w.payload[0];
                  oil_t = w.payload[1];
                  batt = w.payload[2];
               end
               KIND_STATUS_FRAME: begin
                  status = {w.payload[0][7:3], w.payload[1][7:5]};
               end
               default: begin
                  lap_last = {w.payload[0], w.payload[1]};
                  lap_cur = {w.payload[2], w.payload[3]};
                  lap_num = {w.payload[4], w.payload[5]};
               end
            endcase
         end
      end else begin
         fault = FAULT_OK;
         if (!latched) begin
            if (thr > thr_lim && brake_p > brk_lim) begin
               if (bad_ticks < trip_ticks) bad_ticks = bad_ticks + 6'd1;
               fault = FAULT_IMPLAUSIBLE;
            end else begin
               bad_ticks = '0;
            end
            if (bad_ticks >= trip_ticks) latched = 1'b1;
         end
         if (latched) fault = FAULT_LATCHED;
         rd[CH_RPM]            = rpm;
         rd[CH_OIL_PRESS]      = {3'd0, oil_p};
         rd[CH_FUEL_PRESS]     = fuel_p;
         rd[CH_THROTTLE]       = {8'd0, thr};
         rd[CH_SPEED]          = {8'd0, speed};
         rd[CH_BRAKE]          = {3'd0, brake_p};
         rd[CH_GEAR]           = {8'd0, gear};
         rd[CH_BIAS]           = {8'd0, bias};
         rd[CH_ENGINE_TEMP]    = {8'd0, eng_t};
         rd[CH_OIL_TEMP]       = {8'd0, oil_t};
         rd[CH_BATTERY]        = {8'd0, batt};
         rd[CH_RADIO]          = {15'd0, status[7]};
         rd[CH_DRS]            = {15'd0, status[6]};
         rd[CH_THROTTLE_STATE] = {13'd0, status[5:3]};
         rd[CH_LAUNCH]         = {15'd0, status[2]};
         rd[CH_AUTOSHIFT]      = {15'd0, status[1]};
         rd[CH_CLUTCH]         = {15'd0, status[0]};
         rd[CH_CUR_LAP_HI]     = lap_cur / 16'd100;
         rd[CH_CUR_LAP_LO]     = lap_cur % 16'd100;
         rd[CH_LAST_LAP_HI]    = lap_last / 16'd100;
         rd[CH_LAST_LAP_LO]    = lap_last % 16'd100;
         rd[CH_LAP_COUNT]      = lap_num;
         rd[CH_FAULT]          = {14'd0, fault};
         rd[CH_FUEL_OK]        = (rpm > rpm_lim && fuel_p < fuel_lim) ? 16'd0 : 16'd1;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            r.channel = c[CHANNEL_W-1:0];
            r.reading = rd[c];
            r.last = (c == NUM_CHANNELS - 1);
            readings_due.push_back(r);
         end
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic can_word_type frame_word(input logic [10:0] id,
                                               input logic [0:7][7:0] p);
      can_word_type w;
      w.mode = MODE_FRAME;
      w.id = id;
      w.payload = p;
      return w;
   endfunction

   function automatic can_word_type tick_word();
      can_word_type w;
      w.mode = MODE_TICK;
      w.id = 11'($urandom_range(2047));
      for (int k = 0; k < 8; k++) w.payload[k] = rand_byte();
      return w;
   endfunction

   // Mostly telemetry frames inside the window and ticks; a few stray identifiers.
   function automatic can_word_type random_word();
      can_word_type w;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 25) return tick_word();
      w.mode = MODE_FRAME;
      if (pick < 88) w.id = id_base + 11'($urandom_range(4));
      else w.id = 11'($urandom_range(2047));
      for (int k = 0; k < 8; k++) w.payload[k] = rand_byte();
      return w;
   endfunction

   task automatic write_reg(input csr_reg_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_FRAME_ID_BASE:       id_base = data[10:0];
         REG_THROTTLE_LIMIT:      thr_lim = data[7:0];
         REG_BRAKE_LIMIT:         brk_lim = data[12:0];
         REG_FAULT_TICKS:         trip_ticks = data[5:0];
         REG_RPM_LIMIT:           rpm_lim = data;
         REG_FUEL_PRESSURE_LIMIT: fuel_lim = data;
         default: ;
      endcase
   endtask

   // Wait until every word is sent and every reading is back, then let stray frames retire.
   task automatic settle();
      do @(negedge clock);
      while (words_to_send.size() != 0 || req_valid || readings_due.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : driver
      can_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            decode_and_report({req_mode, req_frame_id, req_byte_0, req_byte_1, req_byte_2,
                               req_byte_3, req_byte_4, req_byte_5, req_byte_6, req_byte_7});
         // hold a stalled word; otherwise advance or idle
         if (!req_valid || !req_stall) begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = words_to_send.pop_front();
               req_valid <= 1'b1;
               req_mode <= nxt.mode;
               req_frame_id <= nxt.id;
               req_byte_0 <= nxt.payload[0];
               req_byte_1 <= nxt.payload[1];
               req_byte_2 <= nxt.payload[2];
               req_byte_3 <= nxt.payload[3];
               req_byte_4 <= nxt.payload[4];
               req_byte_5 <= nxt.payload[5];
               req_byte_6 <= nxt.payload[6];
               req_byte_7 <= nxt.payload[7];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_armed && !hold_done) begin
         // long back-pressure so the input queue fills and stalls
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      reading_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            $display("%0t: expected no word, actual channel %0d reading %0d", $time,
                     rsp_channel, rsp_reading);
            mismatches++;
         end else begin
            due = readings_due.pop_front();
            if (rsp_channel !== due.channel) begin
               $display("%0t: channel expected %0d actual %0d", $time, due.channel,
                        rsp_channel);
               mismatches++;
            end
            if (rsp_reading !== due.reading) begin
               $display("%0t: channel %0d reading expected %0d actual %0d", $time,
                        due.channel, due.reading, rsp_reading);
               mismatches++;
            end
            if (rsp_last_channel !== due.last) begin
               $display("%0t: channel %0d last_channel expected %0b actual %0b", $time,
                        due.channel, due.last, rsp_last_channel);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[can_telemetry_decode_bspd_monitor] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      send_idle_pct = 36;
      recv_idle_pct = 64;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset state, all-ones fields, limit boundaries, status bits, stray ids
      words_to_send.push_back(tick_word());
      for (int k = 0; k < 5; k++)
         words_to_send.push_back(frame_word(id_base + 11'(k), '1));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base, 64'h1234_0009_0010_1507));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base, 64'h03E8_000A_0140_1680));
      words_to_send.push_back(frame_word(id_base + 11'd1, 64'h0013_0000_0000_0340));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base + 11'd1, 64'h0014_AAAA_5555_043C));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base + 11'd3, 64'hA85F_0000_0000_0000));
      words_to_send.push_back(frame_word(id_base + 11'd4, 64'h3039_0063_FFFF_0000));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base + 11'd3, 64'h57A0_FFFF_FFFF_FFFF));
      words_to_send.push_back(frame_word(id_base + 11'd5, 64'h0102_0304_0506_0708));
      words_to_send.push_back(frame_word(id_base - 11'd1, 64'h1111_2222_3333_4444));
      words_to_send.push_back(frame_word(11'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      words_to_send.push_back(frame_word(11'd2047, 64'h0000_0000_0000_0000));
      words_to_send.push_back(tick_word());
      settle();

      // window wrapping past the top identifier
      write_reg(REG_FRAME_ID_BASE, 16'd2046);
      @(negedge clock);
      for (int k = 0; k < 5; k++)
         words_to_send.push_back(frame_word(id_base + 11'(k),
                                             {8'(k + 1), 8'h5A, 8'h3C, 8'hC3, 8'h01, 8'h02,
                                              8'(k + 30), 8'hE0}));
      words_to_send.push_back(tick_word());
      settle();

      write_reg(REG_FRAME_ID_BASE, 16'($urandom_range(2047)));
      write_reg(REG_THROTTLE_LIMIT, 16'd128);
      write_reg(REG_BRAKE_LIMIT, 16'd3000);
      write_reg(REG_FAULT_TICKS, 16'd63);
      write_reg(REG_RPM_LIMIT, 16'd30000);
      write_reg(REG_FUEL_PRESSURE_LIMIT, 16'd30000);
      @(negedge clock);
      for (int k = 0; k < 55; k++) words_to_send.push_back(random_word());
      settle();

      // zero limits, masked upper data bits, spare indexes; long receiver hold-off
      write_reg(REG_FRAME_ID_BASE, 16'hF800);
      write_reg(REG_THROTTLE_LIMIT, 16'h0000);
      write_reg(REG_BRAKE_LIMIT, 16'h0000);
      write_reg(REG_FAULT_TICKS, 16'hFFFF);
      write_reg(REG_RPM_LIMIT, 16'h0000);
      write_reg(REG_FUEL_PRESSURE_LIMIT, 16'hFFFF);
      write_reg(REG_SPARE_6, 16'hFFFF);
      write_reg(REG_SPARE_7, 16'h5A5A);
      @(negedge clock);
      send_idle_pct = 64;
      recv_idle_pct = 36;
      hold_armed = 1'b1;
      for (int k = 0; k < 55; k++) words_to_send.push_back(random_word());
      settle();

      write_reg(REG_FRAME_ID_BASE, 16'd2047);
      write_reg(REG_THROTTLE_LIMIT, 16'd255);
      write_reg(REG_BRAKE_LIMIT, 16'd6553);
      write_reg(REG_FAULT_TICKS, 16'd40);
      write_reg(REG_RPM_LIMIT, 16'hFFFF);
      write_reg(REG_FUEL_PRESSURE_LIMIT, 16'd0);
      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 50; k++) words_to_send.push_back(random_word());
      settle();

      // count up, clear, then count to the limit and latch
      write_reg(REG_FRAME_ID_BASE, 16'd1600);
      write_reg(REG_THROTTLE_LIMIT, 16'd21);
      write_reg(REG_BRAKE_LIMIT, 16'd1);
      write_reg(REG_FAULT_TICKS, 16'd4);
      write_reg(REG_RPM_LIMIT, 16'd1000);
      write_reg(REG_FUEL_PRESSURE_LIMIT, 16'd320);
      @(negedge clock);
      words_to_send.push_back(frame_word(id_base, 64'h1000_0064_0010_C850));
      words_to_send.push_back(frame_word(id_base + 11'd1, 64'hFFF0_0000_0000_0332));
      repeat (3) words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base + 11'd1, 64'h0000_0000_0000_0332));
      words_to_send.push_back(tick_word());
      words_to_send.push_back(frame_word(id_base + 11'd1, 64'h8000_0000_0000_0332));
      repeat (5) words_to_send.push_back(tick_word());
      settle();

      write_reg(REG_FAULT_TICKS, 16'd0);
      @(negedge clock);
      for (int k = 0; k < 10; k++) words_to_send.push_back(random_word());
      settle();

      if (mismatches == 0) begin
         $display("[can_telemetry_decode_bspd_monitor] OK");
      end else begin
         $display("[can_telemetry_decode_bspd_monitor] ERROR");
      end
      $finish;
   end

endmodule
